@@ rtl/se2osd_pkg.sv @@
// ----------------------------------------------------------------------------
// se2osd_pkg
// Shared types, constants and tables of the se2 odometry step delta unit.
// ----------------------------------------------------------------------------
`default_nettype none

package se2osd_pkg;

	localparam int MAX_ITER      = 24;
	localparam int CORDIC_ITER_D = 16;
	localparam int ITW           = $clog2(MAX_ITER);

	localparam int CW  = 34;   // cordic vector and angle width
	localparam int TW  = 20;   // rounded cos / sin width
	localparam int PW  = 40;   // position width, q24.16 cm
	localparam int DW  = 41;   // position difference width
	localparam int AW  = 62;   // accumulator width
	localparam int MAW = 22;   // multiplier operand a width
	localparam int MPW = MAW + TW;

	localparam logic signed [CW-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;
	localparam logic signed [16:0]   HALF_PI_Q13     = 17'sd12868;
	localparam logic signed [16:0]   PI_Q13          = 17'sd25736;
	localparam logic signed [16:0]   TWO_PI_Q13      = 17'sd51472;
	localparam logic signed [15:0]   OFFSET_RESET    = 16'sd15;

	localparam logic signed [CW-1:0] ATAN_Q29 [0:MAX_ITER-1] = '{
		34'sd421657428, 34'sd248918915, 34'sd131521918, 34'sd66762580,
		34'sd33510843, 34'sd16771757, 34'sd8387925, 34'sd4194219,
		34'sd2097141, 34'sd1048575, 34'sd524288, 34'sd262144,
		34'sd131072, 34'sd65536, 34'sd32768, 34'sd16384,
		34'sd8192, 34'sd4096, 34'sd2048, 34'sd1024,
		34'sd512, 34'sd256, 34'sd128, 34'sd64
	};

	typedef enum logic [3:0] {
		MAC_NONE,
		MAC_OFF_C,
		MAC_OFF_S,
		MAC_CP_DXL,
		MAC_CP_DXH,
		MAC_SP_DYL,
		MAC_SP_DYH,
		MAC_CP_DYL,
		MAC_CP_DYH,
		MAC_SP_DXL,
		MAC_SP_DXH
	} mac_op_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_COR_INIT,
		ST_COR_RUN,
		ST_COR_DONE,
		ST_OFF_C,
		ST_OFF_S,
		ST_SX_WAIT,
		ST_DIFF,
		ST_RX_CL,
		ST_RX_CH,
		ST_RX_SL,
		ST_RX_SH,
		ST_RX_WAIT,
		ST_RX_LATCH,
		ST_RY_CL,
		ST_RY_CH,
		ST_RY_SL,
		ST_RY_SH,
		ST_RY_WAIT,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic    load;
		logic    cor_init;
		logic    cor_sel;    // 0 current heading, 1 previous heading
		logic    cor_step;
		logic    cor_latch;
		mac_op_t mac;
		logic    diff;
		logic    lat_rx;
		logic    finish;
	} cmd_t;

	typedef struct packed {
		logic cor_last;
	} sts_t;

endpackage

`default_nettype wire

@@ rtl/se2osd_if.sv @@
// ----------------------------------------------------------------------------
// se2osd channel interfaces
// Pose input, step output and offset configuration channels.
// ----------------------------------------------------------------------------
`default_nettype none

interface se2osd_pose_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;
	logic signed [15:0] heading;
	modport source (output valid, pos_x, pos_y, heading, input ready);
	modport sink (input valid, pos_x, pos_y, heading, output ready);
endinterface

interface se2osd_step_if;
	logic               valid;
	logic               ready;
	logic signed [39:0] step_x;
	logic signed [39:0] step_y;
	logic signed [15:0] step_heading;
	modport source (output valid, step_x, step_y, step_heading, input ready);
	modport sink (input valid, step_x, step_y, step_heading, output ready);
endinterface

interface se2osd_cfg_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] data;
	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

`default_nettype wire

@@ rtl/se2osd_dpath.sv @@
// ----------------------------------------------------------------------------
// se2osd_dpath
// Cordic sin/cos unit, shared multiply-accumulate and pose state registers.
// ----------------------------------------------------------------------------
`default_nettype none

module se2osd_dpath #(
	parameter int CORDIC_ITERATIONS = se2osd_pkg::CORDIC_ITER_D
) (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire se2osd_pkg::cmd_t     cmd,
	output se2osd_pkg::sts_t          sts,
	input  wire logic signed [31:0]   pos_x,
	input  wire logic signed [31:0]   pos_y,
	input  wire logic signed [15:0]   heading,
	input  wire logic                 cfg_wr,
	input  wire logic signed [15:0]   cfg_data,
	output logic signed [39:0]        step_x,
	output logic signed [39:0]        step_y,
	output logic signed [15:0]        step_heading
);

	localparam int CW  = se2osd_pkg::CW;
	localparam int TW  = se2osd_pkg::TW;
	localparam int PW  = se2osd_pkg::PW;
	localparam int DW  = se2osd_pkg::DW;
	localparam int AW  = se2osd_pkg::AW;
	localparam int MAW = se2osd_pkg::MAW;
	localparam int MPW = se2osd_pkg::MPW;
	localparam int ITW = se2osd_pkg::ITW;

	// pose state
	logic signed [15:0]   off_q;
	logic signed [PW-1:0] prev_x_q, prev_y_q;
	logic signed [15:0]   prev_h_q;

	// item registers
	logic signed [15:0]   h_q;
	logic signed [PW-1:0] sx_q, sy_q;
	logic signed [DW-1:0] dx_q, dy_q;

	// cordic
	logic signed [CW-1:0] x_q, y_q, z_q;
	logic [ITW-1:0]       it_q;
	logic                 sel_q, neg_q;
	logic signed [TW-1:0] c_q, s_q, cp_q, sp_q;

	// multiply-accumulate
	logic signed [MAW-1:0] ma;
	logic signed [TW-1:0]  mb;
	logic signed [MPW-1:0] prod;
	logic signed [MPW-1:0] prod_s1;
	se2osd_pkg::mac_op_t   mac_s1;
	logic signed [AW-1:0]  acc_q, acc_d, term;
	logic                  acc_en, acc_clr, acc_sub, acc_hi;
	logic signed [AW-1:0]  rnd;
	logic signed [39:0]    rx_q;

	logic signed [15:0]    ang, ang_r;
	logic                  ang_neg;
	logic signed [16:0]    ang17;
	logic signed [CW-1:0]  xs, ys;
	logic signed [CW-1:0]  xr, yr;
	logic signed [TW-1:0]  cv, sv;
	logic signed [16:0]    dh;
	logic signed [PW-1:0]  px40, py40;

	function automatic logic signed [39:0] sat40(input logic signed [AW-1:0] a);
		logic signed [39:0] r;
		r = a[39:0];
		if (!a[AW-1] && (|a[AW-2:39]))
			r = {1'b0, {39{1'b1}}};
		else if (a[AW-1] && !(&a[AW-2:39]))
			r = {1'b1, {39{1'b0}}};
		return r;
	endfunction

	assign sts.cor_last = (it_q == ITW'(CORDIC_ITERATIONS - 1));

	// range reduction into plus or minus half pi
	always_comb begin
		ang   = cmd.cor_sel ? prev_h_q : h_q;
		ang17 = {ang[15], ang};
		ang_r = ang;
		ang_neg = 1'b0;
		if (ang17 > se2osd_pkg::HALF_PI_Q13) begin
			ang_r   = 16'(ang17 - se2osd_pkg::PI_Q13);
			ang_neg = 1'b1;
		end else if (ang17 < -se2osd_pkg::HALF_PI_Q13) begin
			ang_r   = 16'(ang17 + se2osd_pkg::PI_Q13);
			ang_neg = 1'b1;
		end
	end

	assign xs = x_q >>> it_q;
	assign ys = y_q >>> it_q;
	assign xr = x_q + CW'(8192);
	assign yr = y_q + CW'(8192);
	assign cv = neg_q ? -xr[CW-1:14] : xr[CW-1:14];
	assign sv = neg_q ? -yr[CW-1:14] : yr[CW-1:14];

	always_ff @(posedge clk) begin
		if (cmd.cor_init) begin
			x_q   <= se2osd_pkg::CORDIC_GAIN_Q30;
			y_q   <= '0;
			z_q   <= {{2{ang_r[15]}}, ang_r, 16'b0};
			it_q  <= '0;
			sel_q <= cmd.cor_sel;
			neg_q <= ang_neg;
		end else if (cmd.cor_step) begin
			if (!z_q[CW-1]) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - se2osd_pkg::ATAN_Q29[it_q];
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + se2osd_pkg::ATAN_Q29[it_q];
			end
			it_q <= it_q + ITW'(1);
		end
		if (cmd.cor_latch) begin
			if (sel_q) begin
				cp_q <= cv;
				sp_q <= sv;
			end else begin
				c_q <= cv;
				s_q <= sv;
			end
		end
	end

	// multiplier operand select
	always_comb begin
		ma = '0;
		mb = '0;
		case (cmd.mac)
			se2osd_pkg::MAC_OFF_C: begin
				ma = MAW'(off_q);
				mb = c_q;
			end
			se2osd_pkg::MAC_OFF_S: begin
				ma = MAW'(off_q);
				mb = s_q;
			end
			se2osd_pkg::MAC_CP_DXL: begin
				ma = {1'b0, dx_q[20:0]};
				mb = cp_q;
			end
			se2osd_pkg::MAC_CP_DXH: begin
				ma = {{2{dx_q[DW-1]}}, dx_q[DW-1:21]};
				mb = cp_q;
			end
			se2osd_pkg::MAC_SP_DYL: begin
				ma = {1'b0, dy_q[20:0]};
				mb = sp_q;
			end
			se2osd_pkg::MAC_SP_DYH: begin
				ma = {{2{dy_q[DW-1]}}, dy_q[DW-1:21]};
				mb = sp_q;
			end
			se2osd_pkg::MAC_CP_DYL: begin
				ma = {1'b0, dy_q[20:0]};
				mb = cp_q;
			end
			se2osd_pkg::MAC_CP_DYH: begin
				ma = {{2{dy_q[DW-1]}}, dy_q[DW-1:21]};
				mb = cp_q;
			end
			se2osd_pkg::MAC_SP_DXL: begin
				ma = {1'b0, dx_q[20:0]};
				mb = sp_q;
			end
			se2osd_pkg::MAC_SP_DXH: begin
				ma = {{2{dx_q[DW-1]}}, dx_q[DW-1:21]};
				mb = sp_q;
			end
			default: begin
				ma = '0;
				mb = '0;
			end
		endcase
	end

	assign prod = ma * mb;

	always_ff @(posedge clk) begin
		prod_s1 <= prod;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mac_s1 <= se2osd_pkg::MAC_NONE;
		end else begin
			mac_s1 <= cmd.mac;
		end
	end

	// accumulate stage decode
	always_comb begin
		acc_en  = 1'b1;
		acc_clr = 1'b0;
		acc_sub = 1'b0;
		acc_hi  = 1'b0;
		case (mac_s1)
			se2osd_pkg::MAC_CP_DXL: acc_clr = 1'b1;
			se2osd_pkg::MAC_CP_DYL: acc_clr = 1'b1;
			se2osd_pkg::MAC_CP_DXH: acc_hi = 1'b1;
			se2osd_pkg::MAC_SP_DYH: acc_hi = 1'b1;
			se2osd_pkg::MAC_CP_DYH: acc_hi = 1'b1;
			se2osd_pkg::MAC_SP_DYL: acc_en = 1'b1;
			se2osd_pkg::MAC_SP_DXL: acc_sub = 1'b1;
			se2osd_pkg::MAC_SP_DXH: begin
				acc_sub = 1'b1;
				acc_hi  = 1'b1;
			end
			default: acc_en = 1'b0;
		endcase
		term  = acc_hi ? (AW'(prod_s1) <<< 21) : AW'(prod_s1);
		acc_d = (acc_clr ? '0 : acc_q) + (acc_sub ? -term : term);
	end

	always_ff @(posedge clk) begin
		if (acc_en)
			acc_q <= acc_d;
	end

	assign rnd = (acc_q + AW'(32768)) >>> 16;

	assign px40 = PW'(pos_x);
	assign py40 = PW'(pos_y);

	// heading change, one wrap step
	always_comb begin
		dh = {h_q[15], h_q} - {prev_h_q[15], prev_h_q};
		if (dh > se2osd_pkg::PI_Q13)
			dh = dh - se2osd_pkg::TWO_PI_Q13;
		else if (dh < -se2osd_pkg::PI_Q13)
			dh = dh + se2osd_pkg::TWO_PI_Q13;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			h_q  <= heading;
			sx_q <= (px40 <<< 6) + (px40 <<< 5) + (px40 <<< 2);
			sy_q <= (py40 <<< 6) + (py40 <<< 5) + (py40 <<< 2);
		end else if (mac_s1 == se2osd_pkg::MAC_OFF_C) begin
			sx_q <= sx_q + prod_s1[PW-1:0];
		end else if (mac_s1 == se2osd_pkg::MAC_OFF_S) begin
			sy_q <= sy_q + prod_s1[PW-1:0];
		end
		if (cmd.diff) begin
			dx_q <= DW'(sx_q) - DW'(prev_x_q);
			dy_q <= DW'(sy_q) - DW'(prev_y_q);
		end
		if (cmd.lat_rx)
			rx_q <= sat40(rnd);
		if (cmd.finish) begin
			step_x       <= rx_q;
			step_y       <= sat40(rnd);
			step_heading <= dh[15:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_q    <= se2osd_pkg::OFFSET_RESET;
			prev_x_q <= {{8{se2osd_pkg::OFFSET_RESET[15]}}, se2osd_pkg::OFFSET_RESET, 16'b0};
			prev_y_q <= '0;
			prev_h_q <= '0;
		end else if (cfg_wr) begin
			// new offset starts a new track
			off_q    <= cfg_data;
			prev_x_q <= {{8{cfg_data[15]}}, cfg_data, 16'b0};
			prev_y_q <= '0;
			prev_h_q <= '0;
		end else if (cmd.finish) begin
			prev_x_q <= sx_q;
			prev_y_q <= sy_q;
			prev_h_q <= h_q;
		end
	end

endmodule

`default_nettype wire

@@ rtl/se2osd_ctrl.sv @@
// ----------------------------------------------------------------------------
// se2osd_ctrl
// Sequencer of the step delta unit: cordic passes, multiply steps, output.
// ----------------------------------------------------------------------------
`default_nettype none

module se2osd_ctrl (
	input  wire                clk,
	input  wire                arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  wire logic          out_ready,
	output se2osd_pkg::cmd_t   cmd,
	input  wire se2osd_pkg::sts_t sts
);

	se2osd_pkg::state_t state_q, state_d;
	logic pass_q, pass_d;
	logic out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= se2osd_pkg::ST_IDLE;
			pass_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			pass_q  <= pass_d;
			if (cmd.finish)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

	always_comb begin
		state_d       = state_q;
		pass_d        = pass_q;
		in_ready      = 1'b0;
		cmd.load      = 1'b0;
		cmd.cor_init  = 1'b0;
		cmd.cor_sel   = pass_q;
		cmd.cor_step  = 1'b0;
		cmd.cor_latch = 1'b0;
		cmd.mac       = se2osd_pkg::MAC_NONE;
		cmd.diff      = 1'b0;
		cmd.lat_rx    = 1'b0;
		cmd.finish    = 1'b0;
		case (state_q)
			se2osd_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					pass_d   = 1'b0;
					state_d  = se2osd_pkg::ST_COR_INIT;
				end
			end
			se2osd_pkg::ST_COR_INIT: begin
				cmd.cor_init = 1'b1;
				state_d      = se2osd_pkg::ST_COR_RUN;
			end
			se2osd_pkg::ST_COR_RUN: begin
				cmd.cor_step = 1'b1;
				if (sts.cor_last)
					state_d = se2osd_pkg::ST_COR_DONE;
			end
			se2osd_pkg::ST_COR_DONE: begin
				cmd.cor_latch = 1'b1;
				if (!pass_q) begin
					pass_d  = 1'b1;
					state_d = se2osd_pkg::ST_COR_INIT;
				end else begin
					state_d = se2osd_pkg::ST_OFF_C;
				end
			end
			se2osd_pkg::ST_OFF_C: begin
				cmd.mac = se2osd_pkg::MAC_OFF_C;
				state_d = se2osd_pkg::ST_OFF_S;
			end
			se2osd_pkg::ST_OFF_S: begin
				cmd.mac = se2osd_pkg::MAC_OFF_S;
				state_d = se2osd_pkg::ST_SX_WAIT;
			end
			se2osd_pkg::ST_SX_WAIT: state_d = se2osd_pkg::ST_DIFF;
			se2osd_pkg::ST_DIFF: begin
				cmd.diff = 1'b1;
				state_d  = se2osd_pkg::ST_RX_CL;
			end
			se2osd_pkg::ST_RX_CL: begin
				cmd.mac = se2osd_pkg::MAC_CP_DXL;
				state_d = se2osd_pkg::ST_RX_CH;
			end
			se2osd_pkg::ST_RX_CH: begin
				cmd.mac = se2osd_pkg::MAC_CP_DXH;
				state_d = se2osd_pkg::ST_RX_SL;
			end
			se2osd_pkg::ST_RX_SL: begin
				cmd.mac = se2osd_pkg::MAC_SP_DYL;
				state_d = se2osd_pkg::ST_RX_SH;
			end
			se2osd_pkg::ST_RX_SH: begin
				cmd.mac = se2osd_pkg::MAC_SP_DYH;
				state_d = se2osd_pkg::ST_RX_WAIT;
			end
			se2osd_pkg::ST_RX_WAIT: state_d = se2osd_pkg::ST_RX_LATCH;
			se2osd_pkg::ST_RX_LATCH: begin
				cmd.lat_rx = 1'b1;
				state_d    = se2osd_pkg::ST_RY_CL;
			end
			se2osd_pkg::ST_RY_CL: begin
				cmd.mac = se2osd_pkg::MAC_CP_DYL;
				state_d = se2osd_pkg::ST_RY_CH;
			end
			se2osd_pkg::ST_RY_CH: begin
				cmd.mac = se2osd_pkg::MAC_CP_DYH;
				state_d = se2osd_pkg::ST_RY_SL;
			end
			se2osd_pkg::ST_RY_SL: begin
				cmd.mac = se2osd_pkg::MAC_SP_DXL;
				state_d = se2osd_pkg::ST_RY_SH;
			end
			se2osd_pkg::ST_RY_SH: begin
				cmd.mac = se2osd_pkg::MAC_SP_DXH;
				state_d = se2osd_pkg::ST_RY_WAIT;
			end
			se2osd_pkg::ST_RY_WAIT: state_d = se2osd_pkg::ST_FINISH;
			se2osd_pkg::ST_FINISH: begin
				// hold until the output register is free
				if (!out_valid_q || out_ready) begin
					cmd.finish = 1'b1;
					state_d    = se2osd_pkg::ST_IDLE;
				end
			end
			default: state_d = se2osd_pkg::ST_IDLE;
		endcase
	end

	a_finish_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> (!out_valid_q || out_ready))
		else $error("result overwrites a pending transfer");

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == se2osd_pkg::ST_COR_INIT && !pass_q))
		else $error("accepted pose did not start the first cordic pass");

	a_finish_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> (out_valid && state_q == se2osd_pkg::ST_IDLE))
		else $error("finished result not presented");

	a_cordic_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == se2osd_pkg::ST_COR_RUN && sts.cor_last)
		|=> state_q == se2osd_pkg::ST_COR_DONE)
		else $error("cordic run did not end on last iteration");

endmodule

`default_nettype wire

@@ rtl/se2_odometry_step_delta_unit.sv @@
// ----------------------------------------------------------------------------
// se2_odometry_step_delta_unit
// Relative se2 step of the sensor pose from absolute odometry poses.
// ----------------------------------------------------------------------------
// channel  dir  payload
// pose     in   pos_x[31:0] pos_y[31:0] heading[15:0]
// step     out  step_x[39:0] step_y[39:0] step_heading[15:0]
// cfg      in   data[15:0] (sensor offset, cm)
//
// one pose passes twice through the shared cordic unit, then through ten
// multiply steps, before its result reaches the output register
// a new pose is taken once the previous one has reached the output register
// the result waits in the output register while step is stalled
// arst_n clears the sequencer; offset resets to 15 cm, the previous pose to
// (offset, 0, 0); an offset write reloads that start pose
`default_nettype none

module se2_odometry_step_delta_unit #(
	parameter int CORDIC_ITERATIONS = se2osd_pkg::CORDIC_ITER_D
) (
	input wire           clk,
	input wire           arst_n,
	se2osd_pose_if.sink  pose,
	se2osd_step_if.source step,
	se2osd_cfg_if.sink   cfg
);

	se2osd_pkg::cmd_t cmd;
	se2osd_pkg::sts_t sts;

	assign cfg.ready = 1'b1;

	se2osd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (pose.valid),
		.in_ready  (pose.ready),
		.out_valid (step.valid),
		.out_ready (step.ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	se2osd_dpath #(
		.CORDIC_ITERATIONS (CORDIC_ITERATIONS)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.pos_x        (pose.pos_x),
		.pos_y        (pose.pos_y),
		.heading      (pose.heading),
		.cfg_wr       (cfg.valid),
		.cfg_data     (cfg.data),
		.step_x       (step.step_x),
		.step_y       (step.step_y),
		.step_heading (step.step_heading)
	);

endmodule

`default_nettype wire
